// File: design/cbpg_pkg.sv
`default_nettype none

package cbpg_pkg;

    // field widths
    localparam int COORD_W      = 16;
    localparam int CNT_W        = 6;
    localparam int OUT_W        = 24;
    localparam int FRAC_BITS    = 8;
    localparam int MAX_SEGMENTS = 63;

    // stream packing
    localparam int IN_TDATA_W   = 136;
    localparam int OUT_TDATA_W  = 56;

    // datapath widths
    localparam int SQ_W         = 2 * CNT_W;   // products of two 6-bit values
    localparam int WGT_W        = 18;          // cubic weights, n^3 <= 250047
    localparam int PROD_W       = 34;          // weight times coordinate, also the weighted sum
    localparam int DIVS_W       = WGT_W + 1;   // divisor 2*n^3
    localparam int DVD_W        = 43;          // dividend 2*|num|*256 + n^3
    localparam int QUO_W        = OUT_W;       // rounded magnitude, up to 2^23

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_point;

    typedef struct packed {
        t_point p0;   // start
        t_point p1;   // control near start
        t_point p2;   // control near end
        t_point p3;   // end
    } t_curve;

    typedef struct packed {
        logic [CNT_W-1:0] idx;
        logic             last;
    } t_tag;

    // one point request from the sequencer
    typedef struct packed {
        logic             valid;
        t_tag             tag;
        logic [CNT_W-1:0] n;
        t_curve           curve;
    } t_job;

    // divider request for both coordinates
    typedef struct packed {
        logic              valid;
        t_tag              tag;
        logic              neg_x;
        logic              neg_y;
        logic [DVD_W-1:0]  dvd_x;
        logic [DVD_W-1:0]  dvd_y;
        logic [DIVS_W-1:0] dvs;
    } t_div;

    // rounded magnitudes leaving the divider
    typedef struct packed {
        logic             valid;
        t_tag             tag;
        logic             neg_x;
        logic             neg_y;
        logic [QUO_W-1:0] quo_x;
        logic [QUO_W-1:0] quo_y;
    } t_quo;

endpackage

`default_nettype wire

// File: design/cbpg_sequencer.sv
`default_nettype none

module cbpg_sequencer (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire cbpg_pkg::t_curve          i_curve,
    input  wire logic [cbpg_pkg::CNT_W-1:0] i_count,
    input  wire logic                      i_advance,
    output cbpg_pkg::t_job                 o_job
);
    import cbpg_pkg::*;

    logic             r_busy;
    logic [CNT_W-1:0] r_idx;
    logic [CNT_W-1:0] r_n;
    t_curve           r_curve;

    logic [CNT_W-1:0] w_count_sat;
    logic             w_last;

    assign o_ready     = !r_busy;
    assign w_count_sat = (i_count > CNT_W'(MAX_SEGMENTS)) ? CNT_W'(MAX_SEGMENTS) : i_count;
    assign w_last      = (r_idx == r_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (!r_busy) begin
            // a zero count is taken and produces nothing
            if (i_valid) begin
                r_busy <= (w_count_sat != '0);
            end
        end else if (i_advance && w_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_busy && i_valid) begin
            r_idx   <= '0;
            r_n     <= w_count_sat;
            r_curve <= i_curve;
        end else if (r_busy && i_advance) begin
            r_idx <= r_idx + CNT_W'(1);
        end
    end

    always_comb begin
        o_job.valid    = r_busy;
        o_job.tag.idx  = r_idx;
        o_job.tag.last = w_last;
        o_job.n        = r_n;
        o_job.curve    = r_curve;
    end

endmodule

`default_nettype wire

// File: design/cbpg_numerator.sv
`default_nettype none

module cbpg_numerator (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_advance,
    input  wire cbpg_pkg::t_job i_job,
    output cbpg_pkg::t_div      o_div
);
    import cbpg_pkg::*;

    // stage 1: squares and cross product of a = n - i, b = i
    logic             r1_valid;
    t_tag             r1_tag;
    t_curve           r1_curve;
    logic [CNT_W-1:0] r1_a, r1_b, r1_n;
    logic [SQ_W-1:0]  r1_a2, r1_b2, r1_ab, r1_n2;

    // stage 2: the four weights and n^3
    logic             r2_valid;
    t_tag             r2_tag;
    t_curve           r2_curve;
    logic [WGT_W-1:0] r2_w0, r2_w1, r2_w2, r2_w3, r2_den;

    // stage 3: weighted coordinates
    logic                     r3_valid;
    t_tag                     r3_tag;
    logic [WGT_W-1:0]         r3_den;
    logic signed [PROD_W-1:0] r3_px0, r3_px1, r3_px2, r3_px3;
    logic signed [PROD_W-1:0] r3_py0, r3_py1, r3_py2, r3_py3;

    // stage 4: weighted sums
    logic                     r4_valid;
    t_tag                     r4_tag;
    logic [WGT_W-1:0]         r4_den;
    logic signed [PROD_W-1:0] r4_sx, r4_sy;

    // stage 5: divider request
    t_div r5_div;

    logic [CNT_W-1:0] w_a;
    logic [WGT_W-1:0] w_a2b, w_ab2;
    logic [PROD_W-1:0] w_mag_x, w_mag_y;

    assign w_a   = i_job.n - i_job.tag.idx;
    assign w_a2b = WGT_W'(r1_a2) * WGT_W'(r1_b);
    assign w_ab2 = WGT_W'(r1_ab) * WGT_W'(r1_b);

    assign w_mag_x = r4_sx[PROD_W-1] ? (~r4_sx + PROD_W'(1)) : r4_sx;
    assign w_mag_y = r4_sy[PROD_W-1] ? (~r4_sy + PROD_W'(1)) : r4_sy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid     <= 1'b0;
            r2_valid     <= 1'b0;
            r3_valid     <= 1'b0;
            r4_valid     <= 1'b0;
            r5_div.valid <= 1'b0;
        end else if (i_advance) begin
            r1_valid     <= i_job.valid;
            r2_valid     <= r1_valid;
            r3_valid     <= r2_valid;
            r4_valid     <= r3_valid;
            r5_div.valid <= r4_valid;

            r1_tag   <= i_job.tag;
            r1_curve <= i_job.curve;
            r1_a     <= w_a;
            r1_b     <= i_job.tag.idx;
            r1_n     <= i_job.n;
            r1_a2    <= {{CNT_W{1'b0}}, w_a} * {{CNT_W{1'b0}}, w_a};
            r1_b2    <= {{CNT_W{1'b0}}, i_job.tag.idx} * {{CNT_W{1'b0}}, i_job.tag.idx};
            r1_ab    <= {{CNT_W{1'b0}}, w_a} * {{CNT_W{1'b0}}, i_job.tag.idx};
            r1_n2    <= {{CNT_W{1'b0}}, i_job.n} * {{CNT_W{1'b0}}, i_job.n};

            r2_tag   <= r1_tag;
            r2_curve <= r1_curve;
            r2_w0    <= WGT_W'(r1_a2) * WGT_W'(r1_a);
            r2_w1    <= w_a2b + (w_a2b << 1);
            r2_w2    <= w_ab2 + (w_ab2 << 1);
            r2_w3    <= WGT_W'(r1_b2) * WGT_W'(r1_b);
            r2_den   <= WGT_W'(r1_n2) * WGT_W'(r1_n);

            r3_tag   <= r2_tag;
            r3_den   <= r2_den;
            r3_px0   <= PROD_W'($signed({1'b0, r2_w0})) * PROD_W'(r2_curve.p0.x);
            r3_px1   <= PROD_W'($signed({1'b0, r2_w1})) * PROD_W'(r2_curve.p1.x);
            r3_px2   <= PROD_W'($signed({1'b0, r2_w2})) * PROD_W'(r2_curve.p2.x);
            r3_px3   <= PROD_W'($signed({1'b0, r2_w3})) * PROD_W'(r2_curve.p3.x);
            r3_py0   <= PROD_W'($signed({1'b0, r2_w0})) * PROD_W'(r2_curve.p0.y);
            r3_py1   <= PROD_W'($signed({1'b0, r2_w1})) * PROD_W'(r2_curve.p1.y);
            r3_py2   <= PROD_W'($signed({1'b0, r2_w2})) * PROD_W'(r2_curve.p2.y);
            r3_py3   <= PROD_W'($signed({1'b0, r2_w3})) * PROD_W'(r2_curve.p3.y);

            // the weights add up to n^3, so the sums stay inside the product width
            r4_tag   <= r3_tag;
            r4_den   <= r3_den;
            r4_sx    <= (r3_px0 + r3_px1) + (r3_px2 + r3_px3);
            r4_sy    <= (r3_py0 + r3_py1) + (r3_py2 + r3_py3);

            // round to nearest, ties away from zero: (2*|num| + den) / (2*den)
            r5_div.tag   <= r4_tag;
            r5_div.neg_x <= r4_sx[PROD_W-1];
            r5_div.neg_y <= r4_sy[PROD_W-1];
            r5_div.dvd_x <= DVD_W'({w_mag_x, {(FRAC_BITS + 1){1'b0}}}) + DVD_W'(r4_den);
            r5_div.dvd_y <= DVD_W'({w_mag_y, {(FRAC_BITS + 1){1'b0}}}) + DVD_W'(r4_den);
            r5_div.dvs   <= {r4_den, 1'b0};
        end
    end

    assign o_div = r5_div;

endmodule

`default_nettype wire

// File: design/cbpg_divider.sv
`default_nettype none

module cbpg_divider (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_advance,
    input  wire cbpg_pkg::t_div i_div,
    output cbpg_pkg::t_quo      o_quo
);
    import cbpg_pkg::*;

    typedef struct packed {
        logic              valid;
        t_tag              tag;
        logic              neg_x;
        logic              neg_y;
        logic [DIVS_W-1:0] dvs;
        logic [DVD_W-1:0]  rem_x;
        logic [DVD_W-1:0]  rem_y;
        logic [QUO_W-1:0]  quo_x;
        logic [QUO_W-1:0]  quo_y;
    } t_dstage;

    t_dstage w_head;
    t_dstage r_stage [QUO_W];

    always_comb begin
        w_head.valid = i_div.valid;
        w_head.tag   = i_div.tag;
        w_head.neg_x = i_div.neg_x;
        w_head.neg_y = i_div.neg_y;
        w_head.dvs   = i_div.dvs;
        w_head.rem_x = i_div.dvd_x;
        w_head.rem_y = i_div.dvd_y;
        w_head.quo_x = '0;
        w_head.quo_y = '0;
    end

    // restoring division, one quotient bit per stage, msb first
    for (genvar g = 0; g < QUO_W; g++) begin : g_stage
        localparam int BIT = QUO_W - 1 - g;

        t_dstage w_prev;
        t_dstage n_stage;

        if (g == 0) begin : g_first
            assign w_prev = w_head;
        end else begin : g_next
            assign w_prev = r_stage[g-1];
        end

        always_comb begin
            logic [DVD_W-1:0] sh;
            sh      = DVD_W'(w_prev.dvs) << BIT;
            n_stage = w_prev;
            if (w_prev.rem_x >= sh) begin
                n_stage.rem_x      = w_prev.rem_x - sh;
                n_stage.quo_x[BIT] = 1'b1;
            end
            if (w_prev.rem_y >= sh) begin
                n_stage.rem_y      = w_prev.rem_y - sh;
                n_stage.quo_y[BIT] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_stage[g].valid <= 1'b0;
            end else if (i_advance) begin
                r_stage[g] <= n_stage;
            end
        end
    end

    always_comb begin
        o_quo.valid = r_stage[QUO_W-1].valid;
        o_quo.tag   = r_stage[QUO_W-1].tag;
        o_quo.neg_x = r_stage[QUO_W-1].neg_x;
        o_quo.neg_y = r_stage[QUO_W-1].neg_y;
        o_quo.quo_x = r_stage[QUO_W-1].quo_x;
        o_quo.quo_y = r_stage[QUO_W-1].quo_y;
    end

endmodule

`default_nettype wire

// File: design/cubic_bezier_point_generator.sv
`default_nettype none

// cubic bezier point generator: each request on the slave stream carries the four
// points of a cubic curve (start, end, two controls, signed 16-bit integers) and a
// segment count n; the master stream then returns n+1 points, point i being the
// curve at exactly t = i/n, as signed q16.8 rounded to nearest with ties away from
// zero, so point 0 equals the start and point n equals the end. a count above the
// segment limit is clamped to it and a zero count returns nothing. a curve holds
// the slave side while it is loaded and while the sequencer issues its points,
// one point per cycle unless the master side stalls; a zero count is only loaded.
// points then run through a 5-stage weighting pipeline and a 24-stage restoring
// divider (one quotient bit per stage) into the output register. back pressure on
// the master side stalls the whole point pipeline in place; nothing is dropped or
// repeated

module cubic_bezier_point_generator (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,

    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // start_x, start_y, end_x, end_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y,
    // segment_count, zero pad
    input  wire logic [cbpg_pkg::IN_TDATA_W-1:0] s_axis_tdata,

    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // point_x, point_y, point_index, zero pad
    output logic [cbpg_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // last_point
    output logic                                 m_axis_tlast
);
    import cbpg_pkg::*;

    t_curve w_curve;
    logic [CNT_W-1:0] w_count;
    t_job   w_job;
    t_div   w_div;
    t_quo   w_quo;
    logic   w_adv;

    // output register
    logic                    r_out_valid;
    logic [OUT_W-1:0]        r_out_x;
    logic [OUT_W-1:0]        r_out_y;
    logic [CNT_W-1:0]        r_out_idx;
    logic                    r_out_last;

    // unpack the request
    always_comb begin
        w_curve.p0.x = s_axis_tdata[15:0];
        w_curve.p0.y = s_axis_tdata[31:16];
        w_curve.p3.x = s_axis_tdata[47:32];
        w_curve.p3.y = s_axis_tdata[63:48];
        w_curve.p1.x = s_axis_tdata[79:64];
        w_curve.p1.y = s_axis_tdata[95:80];
        w_curve.p2.x = s_axis_tdata[111:96];
        w_curve.p2.y = s_axis_tdata[127:112];
        w_count      = s_axis_tdata[133:128];
    end

    // the whole point pipeline moves unless a result is waiting on the master side
    assign w_adv = !r_out_valid || m_axis_tready;

    cbpg_sequencer u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_curve   (w_curve),
        .i_count   (w_count),
        .i_advance (w_adv),
        .o_job     (w_job)
    );

    cbpg_numerator u_num (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_adv),
        .i_job     (w_job),
        .o_div     (w_div)
    );

    cbpg_divider u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_adv),
        .i_div     (w_div),
        .o_quo     (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_quo.valid;
        end
    end

    // restore the sign of the rounded magnitude
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_x    <= w_quo.neg_x ? (~w_quo.quo_x + OUT_W'(1)) : w_quo.quo_x;
            r_out_y    <= w_quo.neg_y ? (~w_quo.quo_y + OUT_W'(1)) : w_quo.quo_y;
            r_out_idx  <= w_quo.tag.idx;
            r_out_last <= w_quo.tag.last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - 2 * OUT_W - CNT_W){1'b0}}, r_out_idx, r_out_y, r_out_x};
    assign m_axis_tlast  = r_out_last;

    // a curve with a nonzero count starts issuing at index zero right after load
    a_start_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tdata[133:128] != '0))
        |=> (w_job.valid && (w_job.tag.idx == '0)))
        else $error("curve load did not start at index zero");

    // indices step by one while a curve is issued
    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_job.valid && !w_job.tag.last && w_adv)
        |=> (w_job.valid && (w_job.tag.idx == ($past(w_job.tag.idx) + CNT_W'(1)))))
        else $error("point index did not advance by one");

    // a curve has at least one segment, so the first point is never the last
    a_first_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[53:48] == '0)) |-> !m_axis_tlast)
        else $error("point zero flagged as last");

endmodule

`default_nettype wire

// File: tb/testbench.sv
`default_nettype none

module testbench;
    import cbpg_pkg::*;

    localparam int CYCLE_LIMIT    = 2_000_000;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES   = 80;      // pipeline plus divider depth with margin
    localparam int IN_PAD_W       = IN_TDATA_W - 8 * COORD_W - CNT_W;

    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    // one expected point on the master stream
    typedef struct {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic [CNT_W-1:0]        idx;
        logic                    last;
    } t_bezier_point;

    // predicts the points of each accepted curve and checks them in order
    class bezier_scoreboard;
        t_bezier_point pending_points[$];
        int mismatches;
        int curves_seen;
        int empty_curves;
        int points_checked;

        function new();
            mismatches     = 0;
            curves_seen    = 0;
            empty_curves   = 0;
            points_checked = 0;
        endfunction

        function int pending();
            return pending_points.size();
        endfunction

        // exact weighted sum at t = i/n, scaled by 256, rounded half away from zero
        function automatic logic signed [OUT_W-1:0] bezier_coord(longint p0, longint p1,
                longint p2, longint p3, longint n, longint i);
            longint a;
            longint den;
            longint wsum;
            longint mag;
            longint q;
            a    = n - i;
            den  = n * n * n;
            wsum = (a * a * a * p0 + 3 * a * a * i * p1 + 3 * a * i * i * p2
                    + i * i * i * p3) * 256;
            mag  = (wsum < 0) ? -wsum : wsum;
            q    = (2 * mag + den) / (2 * den);
            return OUT_W'((wsum < 0) ? -q : q);
        endfunction

        function void note_curve(logic [IN_TDATA_W-1:0] d);
            longint px[4];
            longint py[4];
            longint n;
            t_bezier_point pt;
            // tdata order: start, end, ctrl1, ctrl2, count
            px[0] = longint'($signed(d[15:0]));
            py[0] = longint'($signed(d[31:16]));
            px[3] = longint'($signed(d[47:32]));
            py[3] = longint'($signed(d[63:48]));
            px[1] = longint'($signed(d[79:64]));
            py[1] = longint'($signed(d[95:80]));
            px[2] = longint'($signed(d[111:96]));
            py[2] = longint'($signed(d[127:112]));
            // a 6-bit count never exceeds the segment limit, so no clamp is needed
            n = longint'(d[8*COORD_W +: CNT_W]);
            curves_seen++;
            if (n == 0) begin
                empty_curves++;
                return;
            end
            for (longint i = 0; i <= n; i++) begin
                if (i == 0) begin
                    pt.x = OUT_W'(px[0] * 256);
                    pt.y = OUT_W'(py[0] * 256);
                end else if (i == n) begin
                    pt.x = OUT_W'(px[3] * 256);
                    pt.y = OUT_W'(py[3] * 256);
                end else begin
                    pt.x = bezier_coord(px[0], px[1], px[2], px[3], n, i);
                    pt.y = bezier_coord(py[0], py[1], py[2], py[3], n, i);
                end
                pt.idx  = i[CNT_W-1:0];
                pt.last = (i == n);
                pending_points.insert(pending_points.size(), pt);
            end
        endfunction

        function void report(string field, longint exp_val, longint act_val);
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field, exp_val, act_val);
        endfunction

        function void check_point(logic [OUT_TDATA_W-1:0] d, logic last);
            t_bezier_point exp_pt;
            logic signed [OUT_W-1:0] act_x;
            logic signed [OUT_W-1:0] act_y;
            logic [CNT_W-1:0] act_idx;
            act_x   = d[OUT_W-1:0];
            act_y   = d[2*OUT_W-1:OUT_W];
            act_idx = d[2*OUT_W +: CNT_W];
            points_checked++;
            if (pending_points.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected point, expected none, actual x %0d y %0d index %0d",
                         $time, act_x, act_y, act_idx);
                return;
            end
            exp_pt = pending_points.pop_front();
            if (act_x !== exp_pt.x)
                report("point_x", longint'(exp_pt.x), longint'(act_x));
            if (act_y !== exp_pt.y)
                report("point_y", longint'(exp_pt.y), longint'(act_y));
            if (act_idx !== exp_pt.idx)
                report("point_index", longint'(exp_pt.idx), longint'(act_idx));
            if (last !== exp_pt.last)
                report("last_point", longint'(exp_pt.last), longint'(last));
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                    m_axis_tlast;

    bezier_scoreboard sb;

    int tx_max_gap  = 17;
    int rx_max_gap  = 17;
    bit rx_hold_req = 1'b0;
    int cycle_cnt   = 0;

    cubic_bezier_point_generator DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 12 time unit period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // both handshakes are seen at the rising edge, before the block updates
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_curve(s_axis_tdata);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_point(m_axis_tdata, m_axis_tlast);
    end

    // hard stop if the run hangs
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles", cycle_cnt);
        $display("Mismatches found");
        $finish;
    end

    // receiver: random wait before each point, or one long hold-off on request
    initial begin
        int gap;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            gap = (rx_max_gap == 0) ? 0 : $urandom_range(0, rx_max_gap);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                gap = RX_HOLD_CYCLES;
            end
            if (gap != 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            @(negedge i_clk);
        end
    end

    function automatic t_curve mk_curve(
            logic signed [COORD_W-1:0] sx, logic signed [COORD_W-1:0] sy,
            logic signed [COORD_W-1:0] c1x, logic signed [COORD_W-1:0] c1y,
            logic signed [COORD_W-1:0] c2x, logic signed [COORD_W-1:0] c2y,
            logic signed [COORD_W-1:0] ex, logic signed [COORD_W-1:0] ey);
        t_curve c;
        c.p0.x = sx;
        c.p0.y = sy;
        c.p1.x = c1x;
        c.p1.y = c1y;
        c.p2.x = c2x;
        c.p2.y = c2y;
        c.p3.x = ex;
        c.p3.y = ey;
        return c;
    endfunction

    // extremes and small values show up often, the rest is full range
    function automatic logic signed [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 7))
            0: return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
            1: return COORD_W'($signed($urandom_range(0, 6)) - 3);
            default: return COORD_W'($urandom());
        endcase
    endfunction

    function automatic logic [CNT_W-1:0] rand_count();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return CNT_W'(MAX_SEGMENTS);
            2: return CNT_W'($urandom_range(1, 3));
            default: return CNT_W'($urandom_range(0, MAX_SEGMENTS));
        endcase
    endfunction

    // call at a falling edge; returns at the falling edge after acceptance
    task automatic send_curve(input t_curve c, input logic [CNT_W-1:0] n);
        int gap;
        gap = (tx_max_gap == 0) ? 0 : $urandom_range(0, tx_max_gap);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{IN_PAD_W{1'b0}}, n, c.p2.y, c.p2.x, c.p1.y, c.p1.x,
                          c.p3.y, c.p3.x, c.p0.y, c.p0.x};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic send_random_curves(input int count);
        for (int k = 0; k < count; k++)
            send_curve(mk_curve(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                                rand_coord(), rand_coord(), rand_coord(), rand_coord()),
                       rand_count());
    endtask

    // sender pauses until every predicted point has come back
    task automatic drain_points();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    initial begin
        sb = new();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed curves
        send_curve(mk_curve(0, 0, 0, 0, 0, 0, 0, 0), 1);
        send_curve(mk_curve(100, -200, 300, -400, 500, -600, 700, -800), 0);
        send_curve(mk_curve(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                            COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX),
                   CNT_W'(MAX_SEGMENTS));
        send_curve(mk_curve(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                            COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN),
                   CNT_W'(MAX_SEGMENTS));
        send_curve(mk_curve(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
                            COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN),
                   CNT_W'(MAX_SEGMENTS));
        send_curve(mk_curve(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
                            COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX), 5);
        // only the two end points
        send_curve(mk_curve(-1234, 4321, 9999, -9999, -5, 5, 2222, -3333), 1);
        send_curve(mk_curve(10, 20, 30, 40, 50, 60, 70, 80), 2);
        send_curve(mk_curve(-7, 3, 11, -13, 17, -19, 23, 29), 3);
        // exact halfway cases at t = 1/16, positive and negative
        send_curve(mk_curve(0, 0, 0, 0, 0, 0, 8, -8), 16);
        send_curve(mk_curve(0, 0, 0, 0, 0, 0, -24, 24), 16);
        // empty curve directly followed by the shortest one
        send_curve(mk_curve(0, 0, 0, 0, 0, 0, 0, 0), 0);
        send_curve(mk_curve(COORD_MAX, COORD_MIN, 0, 0, 0, 0, COORD_MIN, COORD_MAX), 1);
        send_curve(mk_curve(-1, -1, 0, 0, 0, 0, 1, 1), 7);
        send_curve(mk_curve(1, -1, -1, 1, 1, -1, -1, 1), 32);
        send_curve(mk_curve(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                            rand_coord(), rand_coord(), rand_coord(), rand_coord()), 63);
        send_curve(mk_curve(12345, -23456, -31000, 30000, 29000, -28000, -54, 77), 48);
        drain_points();

        // random curves with idling on both sides
        send_random_curves(90);

        // long hold-off on the receiver while the sender keeps pushing
        tx_max_gap  = 0;
        rx_hold_req = 1'b1;
        send_random_curves(15);
        drain_points();

        // stretch with no idling at all
        rx_max_gap = 0;
        send_random_curves(70);

        // idling again on both sides
        tx_max_gap = 17;
        rx_max_gap = 17;
        send_random_curves(75);

        drain_points();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("checked %0d points from %0d curves (%0d with a zero count)",
                 sb.points_checked, sb.curves_seen, sb.empty_curves);
        $display("covered extreme coordinates, halfway rounding, receiver hold-off, no-idle run");
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
